// ===== rtl/rvex_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvex_pkg
// Shared types and constants for the RV32I execute unit: format codes,
// func3 codes, immediate handling constants and the control bundle.
// ----------------------------------------------------------------------------
package rvex_pkg;

	// default width of the pc and target ports
	localparam int unsigned DEF_ADDR_BITS = 16;

	localparam int unsigned XLEN     = 32;
	localparam int unsigned IMM_BITS = 20;

	// link offset, upper immediate shift and jalr alignment mask
	localparam int unsigned LINK_OFFSET = 4;
	localparam int unsigned UPPER_SHIFT = 12;
	localparam logic [XLEN-1:0] ALIGN_MASK = 32'hFFFF_FFFE;

	// instruction formats
	typedef enum logic [2:0] {
		FMT_R = 3'd0,
		FMT_I = 3'd1,
		FMT_S = 3'd2,
		FMT_B = 3'd3,
		FMT_U = 3'd4,
		FMT_J = 3'd5
	} fmt_t;

	// alu operations by func3
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// branch conditions by func3
	localparam logic [2:0] BR_EQ  = 3'd0;
	localparam logic [2:0] BR_NE  = 3'd1;
	localparam logic [2:0] BR_LT  = 3'd4;
	localparam logic [2:0] BR_GE  = 3'd5;
	localparam logic [2:0] BR_LTU = 3'd6;
	localparam logic [2:0] BR_GEU = 3'd7;

	// decoded control fields of one request
	typedef struct packed {
		logic [2:0] cmd;
		logic [2:0] funct3;
		logic       alt;
		logic       jalr;
		logic       load;
		logic       lui;
	} ctrl_t;

	// sign extend the decoded immediate to register width
	function automatic logic [XLEN-1:0] sext_imm(input logic [IMM_BITS-1:0] imm);
		return {{(XLEN-IMM_BITS){imm[IMM_BITS-1]}}, imm};
	endfunction

endpackage

// ===== rtl/rvex_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvex_alu
// Integer ALU and branch comparator: register or immediate operation by
// func3, plus the branch condition on the two source values.
// ----------------------------------------------------------------------------
module rvex_alu (
	input  rvex_pkg::ctrl_t    ctrl,
	input  logic        [31:0] rs1,
	input  logic        [31:0] rs2,
	input  logic        [31:0] imm,
	output logic        [31:0] alu_out,
	output logic               br_taken
);
	import rvex_pkg::*;

	logic [XLEN-1:0] op_b;
	logic [4:0]      shamt;
	logic            is_r;

	// operand select
	assign is_r  = (ctrl.cmd == FMT_R);
	assign op_b  = is_r ? rs2 : imm;
	assign shamt = op_b[4:0];

	// alu operation
	always_comb begin
		case (ctrl.funct3)
			F3_ADD:  alu_out = (is_r && ctrl.alt) ? rs1 - op_b : rs1 + op_b;
			F3_SLL:  alu_out = rs1 << shamt;
			F3_SLT:  alu_out = {31'd0, ($signed(rs1) < $signed(op_b))};
			F3_SLTU: alu_out = {31'd0, (rs1 < op_b)};
			F3_XOR:  alu_out = rs1 ^ op_b;
			F3_SR:   alu_out = ctrl.alt ? XLEN'($signed(rs1) >>> shamt) : rs1 >> shamt;
			F3_OR:   alu_out = rs1 | op_b;
			F3_AND:  alu_out = rs1 & op_b;
			default: alu_out = rs1 & op_b;
		endcase
	end

	// branch condition
	always_comb begin
		unique case (ctrl.funct3)
			BR_EQ:   br_taken = (rs1 == rs2);
			BR_NE:   br_taken = (rs1 != rs2);
			BR_LT:   br_taken = ($signed(rs1) < $signed(rs2));
			BR_GE:   br_taken = ($signed(rs1) >= $signed(rs2));
			BR_LTU:  br_taken = (rs1 < rs2);
			BR_GEU:  br_taken = (rs1 >= rs2);
			default: br_taken = 1'b0;
		endcase
	end

endmodule

// ===== rtl/rvex_agu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvex_agu
// Address and link unit: load/store address, link value, upper immediate
// result and the jump or branch target.
// ----------------------------------------------------------------------------
module rvex_agu #(
	parameter int unsigned ADDR_BITS = rvex_pkg::DEF_ADDR_BITS
) (
	input  rvex_pkg::ctrl_t           ctrl,
	input  logic        [31:0]        rs1,
	input  logic        [31:0]        imm,
	input  logic        [ADDR_BITS-1:0] pc,
	output logic        [31:0]        other_out,
	output logic        [ADDR_BITS-1:0] target
);
	import rvex_pkg::*;

	logic [XLEN-1:0]      base_sum;
	logic [XLEN-1:0]      upper;
	logic [XLEN-1:0]      pc_ext;
	logic [ADDR_BITS-1:0] pc_link;
	logic [XLEN-1:0]      link_ext;
	logic [XLEN-1:0]      jalr_tgt;
	logic [ADDR_BITS-1:0] br_tgt;

	// shared adders
	assign base_sum = rs1 + imm;
	assign upper    = imm << UPPER_SHIFT;
	assign pc_ext   = XLEN'(pc);
	assign pc_link  = pc + ADDR_BITS'(LINK_OFFSET);
	assign link_ext = XLEN'(pc_link);

	// non-alu result by format
	always_comb begin
		unique case (ctrl.cmd)
			FMT_I:   other_out = ctrl.jalr ? link_ext : (ctrl.load ? base_sum : '0);
			FMT_S:   other_out = base_sum;
			FMT_U:   other_out = ctrl.lui ? upper : pc_ext + upper;
			FMT_J:   other_out = link_ext;
			default: other_out = '0;
		endcase
	end

	// jump or branch target
	assign jalr_tgt = base_sum & ALIGN_MASK;
	assign br_tgt   = pc + ADDR_BITS'(imm << 1);
	assign target   = ctrl.jalr ? ADDR_BITS'(jalr_tgt) : br_tgt;

endmodule

// ===== rtl/rv32i_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_execute_unit
// Execute stage of a 32-bit RISC-V integer core: branch condition, ALU
// result, address/link/upper result and jump or branch target.
// ----------------------------------------------------------------------------
// channel   handshake        payload
// request   start / busy     cmd rs1_value rs2_value pc_value immediate
//                            funct3 alt_bit jalr_flag load_flag lui_flag
// result    done (strobe)    branch_taken alu_result other_result target_pc
//
// A request is registered on the edge it is taken; its result is registered
// on the next edge along with the done strobe, one request a cycle.
// busy is never raised: one request can be taken every cycle.
// arst_n clears the stage valid bits only; payload registers are not reset.
// The receiver cannot stall; done is high for exactly one cycle per request.
// ----------------------------------------------------------------------------
module rv32i_execute_unit #(
	parameter int unsigned ADDR_BITS = rvex_pkg::DEF_ADDR_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic        [2:0]           cmd,
	input  logic signed [31:0]          rs1_value,
	input  logic signed [31:0]          rs2_value,
	input  logic        [ADDR_BITS-1:0] pc_value,
	input  logic signed [19:0]          immediate,
	input  logic        [2:0]           funct3,
	input  logic                        alt_bit,
	input  logic                        jalr_flag,
	input  logic                        load_flag,
	input  logic                        lui_flag,
	output logic                        done,
	output logic                        branch_taken,
	output logic signed [31:0]          alu_result,
	output logic signed [31:0]          other_result,
	output logic        [ADDR_BITS-1:0] target_pc
);
	import rvex_pkg::*;

	logic                 take;
	logic                 valid_s1;
	ctrl_t                ctrl_s1;
	logic [XLEN-1:0]      rs1_s1;
	logic [XLEN-1:0]      rs2_s1;
	logic [ADDR_BITS-1:0] pc_s1;
	logic [IMM_BITS-1:0]  imm_s1;
	logic [XLEN-1:0]      imm_ext;
	logic [XLEN-1:0]      alu_val;
	logic                 br_val;
	logic [XLEN-1:0]      other_val;
	logic [ADDR_BITS-1:0] tgt_val;
	logic                 valid_s2;
	logic                 branch_s2;
	logic [XLEN-1:0]      alu_s2;
	logic [XLEN-1:0]      other_s2;
	logic [ADDR_BITS-1:0] target_s2;

	// always ready
	assign busy = 1'b0;
	assign take = start && !busy;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (take) begin
			ctrl_s1 <= '{cmd: cmd, funct3: funct3, alt: alt_bit, jalr: jalr_flag,
				load: load_flag, lui: lui_flag};
			rs1_s1  <= rs1_value;
			rs2_s1  <= rs2_value;
			pc_s1   <= pc_value;
			imm_s1  <= immediate;
		end
	end

	assign imm_ext = sext_imm(imm_s1);

	// alu and branch compare
	rvex_alu u_alu (
		.ctrl     (ctrl_s1),
		.rs1      (rs1_s1),
		.rs2      (rs2_s1),
		.imm      (imm_ext),
		.alu_out  (alu_val),
		.br_taken (br_val)
	);

	// addresses, link and target
	rvex_agu #(
		.ADDR_BITS (ADDR_BITS)
	) u_agu (
		.ctrl      (ctrl_s1),
		.rs1       (rs1_s1),
		.imm       (imm_ext),
		.pc        (pc_s1),
		.other_out (other_val),
		.target    (tgt_val)
	);

	// result register
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			branch_s2 <= br_val;
			alu_s2    <= alu_val;
			other_s2  <= other_val;
			target_s2 <= tgt_val;
		end
	end

	assign done         = valid_s2;
	assign branch_taken = branch_s2;
	assign alu_result   = alu_s2;
	assign other_result = other_s2;
	assign target_pc    = target_s2;

endmodule

// ===== bench/tb_rv32i_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rv32i_execute_unit
// Self-checking bench for the RV32I execute stage. Each decoded instruction
// sent to the unit is run through a local model of the branch compare, ALU,
// address/link/upper path and target adder. Each strobed result is compared
// field by field with the oldest outstanding prediction. Stimulus is a
// directed set of corner instructions, then random instructions with and
// without idle gaps, one full drain pause, and a run biased to edge operands.
// ----------------------------------------------------------------------------
module tb_rv32i_execute_unit;
	import rvex_pkg::*;

	localparam int unsigned ADDR_BITS = DEF_ADDR_BITS;
	localparam int unsigned CYCLE_LIMIT = 100000;
	localparam int unsigned TAIL_CYCLES = 8;

	// format codes with no instruction behind them
	localparam logic [2:0] FMT_RSV6 = 3'd6;
	localparam logic [2:0] FMT_RSV7 = 3'd7;

	// one decoded instruction
	typedef struct {
		logic [2:0]           cmd;
		logic [31:0]          rs1;
		logic [31:0]          rs2;
		logic [ADDR_BITS-1:0] pc;
		logic [19:0]          imm;
		logic [2:0]           funct3;
		logic                 alt;
		logic                 jalr;
		logic                 load;
		logic                 lui;
	} exec_instr_t;

	// the four fields the stage produces
	typedef struct {
		logic                 taken;
		logic [31:0]          alu;
		logic [31:0]          other;
		logic [ADDR_BITS-1:0] target;
	} exec_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic        [2:0]           cmd;
	logic signed [31:0]          rs1_value;
	logic signed [31:0]          rs2_value;
	logic        [ADDR_BITS-1:0] pc_value;
	logic signed [19:0]          immediate;
	logic        [2:0]           funct3;
	logic                        alt_bit;
	logic                        jalr_flag;
	logic                        load_flag;
	logic                        lui_flag;
	logic                        done;
	logic                        branch_taken;
	logic signed [31:0]          alu_result;
	logic signed [31:0]          other_result;
	logic        [ADDR_BITS-1:0] target_pc;

	exec_result_t expected_results[$];
	int           error_count = 0;
	int unsigned  cycle_count = 0;
	bit           gaps_on = 1'b1;

	rv32i_execute_unit #(
		.ADDR_BITS(ADDR_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.rs1_value(rs1_value),
		.rs2_value(rs2_value),
		.pc_value(pc_value),
		.immediate(immediate),
		.funct3(funct3),
		.alt_bit(alt_bit),
		.jalr_flag(jalr_flag),
		.load_flag(load_flag),
		.lui_flag(lui_flag),
		.done(done),
		.branch_taken(branch_taken),
		.alu_result(alu_result),
		.other_result(other_result),
		.target_pc(target_pc)
	);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// expected result of one instruction
	function automatic exec_result_t compute_exec(input exec_instr_t r);
		logic [31:0]          imm_x;
		logic [31:0]          op_b;
		logic [31:0]          addr_sum;
		logic [31:0]          upper;
		logic [31:0]          full_target;
		logic [ADDR_BITS-1:0] pc_link;
		logic [4:0]           shamt;
		exec_result_t         res;
		imm_x    = {{12{r.imm[19]}}, r.imm};
		op_b     = (r.cmd == FMT_R) ? r.rs2 : imm_x;
		shamt    = op_b[4:0];
		addr_sum = r.rs1 + imm_x;
		pc_link  = r.pc + ADDR_BITS'(LINK_OFFSET);
		upper    = imm_x << UPPER_SHIFT;

		// branch compare
		case (r.funct3)
			BR_EQ:   res.taken = (r.rs1 == r.rs2);
			BR_NE:   res.taken = (r.rs1 != r.rs2);
			BR_LT:   res.taken = ($signed(r.rs1) < $signed(r.rs2));
			BR_GE:   res.taken = ($signed(r.rs1) >= $signed(r.rs2));
			BR_LTU:  res.taken = (r.rs1 < r.rs2);
			BR_GEU:  res.taken = (r.rs1 >= r.rs2);
			default: res.taken = 1'b0;
		endcase

		// alu, shift right arithmetic whenever the alternate bit is set
		case (r.funct3)
			F3_ADD:  res.alu = (r.cmd == FMT_R && r.alt) ? r.rs1 - op_b : r.rs1 + op_b;
			F3_SLL:  res.alu = r.rs1 << shamt;
			F3_SLT:  res.alu = {31'b0, $signed(r.rs1) < $signed(op_b)};
			F3_SLTU: res.alu = {31'b0, r.rs1 < op_b};
			F3_XOR:  res.alu = r.rs1 ^ op_b;
			F3_SR: begin
				if (r.alt)
					res.alu = $signed(r.rs1) >>> shamt;
				else
					res.alu = r.rs1 >> shamt;
			end
			F3_OR:   res.alu = r.rs1 | op_b;
			default: res.alu = r.rs1 & op_b;
		endcase

		// address, link or upper immediate
		case (r.cmd)
			FMT_I: begin
				if (r.jalr)
					res.other = 32'(pc_link);
				else if (r.load)
					res.other = addr_sum;
				else
					res.other = '0;
			end
			FMT_S:   res.other = addr_sum;
			FMT_U:   res.other = r.lui ? upper : 32'(r.pc) + upper;
			FMT_J:   res.other = 32'(pc_link);
			default: res.other = '0;
		endcase

		// jump or branch target
		full_target = r.jalr ? (addr_sum & ALIGN_MASK) : 32'(r.pc) + (imm_x << 1);
		res.target  = full_target[ADDR_BITS-1:0];
		return res;
	endfunction

	function automatic exec_instr_t make_instr(input logic [2:0] c, input logic [31:0] a,
		input logic [31:0] b, input logic [ADDR_BITS-1:0] pc, input logic [19:0] imm,
		input logic [2:0] f3, input logic alt, input logic jalr, input logic load,
		input logic lui);
		exec_instr_t r;
		r.cmd    = c;
		r.rs1    = a;
		r.rs2    = b;
		r.pc     = pc;
		r.imm    = imm;
		r.funct3 = f3;
		r.alt    = alt;
		r.jalr   = jalr;
		r.load   = load;
		r.lui    = lui;
		return r;
	endfunction

	// register value, optionally drawn mostly from edge values
	function automatic logic [31:0] pick_operand(input bit edge_bias);
		logic [31:0] v;
		v = $urandom;
		if (edge_bias || $urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 6))
				0: v = 32'h0000_0000;
				1: v = 32'h0000_0001;
				2: v = 32'hFFFF_FFFF;
				3: v = 32'h8000_0000;
				4: v = 32'h7FFF_FFFF;
				5: v = $urandom_range(0, 31);
				default: v = $urandom;
			endcase
		end
		return v;
	endfunction

	function automatic exec_instr_t random_instr(input bit edge_bias);
		exec_instr_t r;
		r.cmd    = 3'($urandom_range(0, 7));
		r.rs1    = pick_operand(edge_bias);
		r.rs2    = ($urandom_range(0, edge_bias ? 3 : 7) == 0) ? r.rs1 :
			pick_operand(edge_bias);
		r.pc     = ADDR_BITS'($urandom);
		r.imm    = 20'($urandom);
		r.funct3 = 3'($urandom_range(0, 7));
		r.alt    = 1'($urandom_range(0, 1));
		r.jalr   = ($urandom_range(0, 3) == 0);
		r.load   = 1'($urandom_range(0, 1));
		r.lui    = 1'($urandom_range(0, 1));
		if (edge_bias) begin
			case ($urandom_range(0, 5))
				0: r.imm = 20'h00000;
				1: r.imm = 20'h00001;
				2: r.imm = 20'hFFFFF;
				3: r.imm = 20'h80000;
				4: r.imm = 20'h7FFFF;
				default: r.imm = 20'($urandom);
			endcase
			if ($urandom_range(0, 3) == 0)
				r.pc = $urandom_range(0, 1) ? '1 : ADDR_BITS'($urandom_range(0, 7));
		end
		return r;
	endfunction

	// idle the request side
	task automatic idle_requests(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// send one request and record its prediction once it is taken
	task automatic issue_instr(input exec_instr_t r);
		if (gaps_on && $urandom_range(0, 99) < 10)
			idle_requests($urandom_range(1, 3));
		start     <= 1'b1;
		cmd       <= r.cmd;
		rs1_value <= r.rs1;
		rs2_value <= r.rs2;
		pc_value  <= r.pc;
		immediate <= r.imm;
		funct3    <= r.funct3;
		alt_bit   <= r.alt;
		jalr_flag <= r.jalr;
		load_flag <= r.load;
		lui_flag  <= r.lui;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		expected_results.push_back(compute_exec(r));
	endtask

	// hold requests off until every outstanding result is back
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin : result_check
		exec_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with no request outstanding", $time);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (branch_taken !== want.taken) begin
					$display("%0t: branch_taken mismatch: expected %b, actual %b",
						$time, want.taken, branch_taken);
					error_count++;
				end
				if (alu_result !== want.alu) begin
					$display("%0t: alu_result mismatch: expected %h, actual %h",
						$time, want.alu, alu_result);
					error_count++;
				end
				if (other_result !== want.other) begin
					$display("%0t: other_result mismatch: expected %h, actual %h",
						$time, want.other, other_result);
					error_count++;
				end
				if (target_pc !== want.target) begin
					$display("%0t: target_pc mismatch: expected %h, actual %h",
						$time, want.target, target_pc);
					error_count++;
				end
			end
		end
	end

	// edge operands for every alu operation, branch condition and format
	task automatic test_directed();
		issue_instr(make_instr(FMT_R, 32'h7FFF_FFFF, 32'h1, 16'h0, 20'h0, F3_ADD, 0, 0, 0, 0));
		issue_instr(make_instr(FMT_R, 32'h8000_0000, 32'h1, 16'h0, 20'h0, F3_ADD, 1, 0, 0, 0));
		issue_instr(make_instr(FMT_R, 32'h1, 32'hFFFF_FFFF, 16'h0, 20'h0, F3_SLL, 0, 0, 0, 0));
		issue_instr(make_instr(FMT_R, 32'h8000_0000, 32'h1F, 16'h0, 20'h0, F3_SR, 1, 0, 0, 0));
		issue_instr(make_instr(FMT_R, 32'h8000_0000, 32'h21, 16'h0, 20'h0, F3_SR, 0, 0, 0, 0));
		issue_instr(make_instr(FMT_R, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 20'h0, F3_SLT,
			0, 0, 0, 0));
		issue_instr(make_instr(FMT_R, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 20'h0, F3_SLTU,
			0, 0, 0, 0));
		issue_instr(make_instr(FMT_R, 32'hFFFF_FFFF, 32'h0, 16'h0, 20'h0, F3_XOR, 0, 0, 0, 0));
		issue_instr(make_instr(FMT_R, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'h0, 20'h0, F3_OR,
			0, 0, 0, 0));
		issue_instr(make_instr(FMT_R, 32'hFFFF_FFFF, 32'h8000_0001, 16'h0, 20'h0, F3_AND,
			0, 0, 0, 0));
		// i-type shift takes its amount from the low immediate bits
		issue_instr(make_instr(FMT_I, 32'hFFFF_FFFF, 32'h0, 16'h0, 20'hFFFE5, F3_SLL,
			0, 0, 0, 0));
		issue_instr(make_instr(FMT_I, 32'h8000_0000, 32'h0, 16'h0, 20'h0001F, F3_SR,
			1, 0, 0, 0));
		// alternate bit does not turn an immediate add into a subtract
		issue_instr(make_instr(FMT_I, 32'h0, 32'h0, 16'h0, 20'h80000, F3_ADD, 1, 0, 0, 0));
		issue_instr(make_instr(FMT_I, 32'h7FFF_FFFF, 32'h0, 16'h0, 20'h7FFFF, F3_SLT,
			0, 0, 0, 0));
		// branch conditions, including the two codes that never take
		issue_instr(make_instr(FMT_B, 32'h5, 32'h5, 16'h0064, 20'hFFFFE, BR_EQ, 0, 0, 0, 0));
		issue_instr(make_instr(FMT_B, 32'h5, 32'h5, 16'h0000, 20'hFFFFF, BR_NE, 0, 0, 0, 0));
		issue_instr(make_instr(FMT_B, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFE, 20'h7FFFF,
			BR_LT, 0, 0, 0, 0));
		issue_instr(make_instr(FMT_B, 32'h8000_0000, 32'h7FFF_FFFF, 16'h1234, 20'h80000,
			BR_GE, 0, 0, 0, 0));
		issue_instr(make_instr(FMT_B, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 20'h1,
			BR_LTU, 0, 0, 0, 0));
		issue_instr(make_instr(FMT_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 20'h1,
			BR_GEU, 0, 0, 0, 0));
		issue_instr(make_instr(FMT_B, 32'h7, 32'h7, 16'h0, 20'h1, F3_SLT, 0, 0, 0, 0));
		issue_instr(make_instr(FMT_B, 32'h7, 32'h7, 16'h0, 20'h1, F3_SLTU, 0, 0, 0, 0));
		// link value wraps within the pc width
		issue_instr(make_instr(FMT_J, 32'h0, 32'h0, 16'hFFFC, 20'h7FFFF, F3_ADD, 0, 0, 0, 0));
		issue_instr(make_instr(FMT_I, 32'h0000_1235, 32'h0, 16'hFFFF, 20'h00002, F3_ADD,
			0, 1, 0, 0));
		// load and store address wrap
		issue_instr(make_instr(FMT_I, 32'hFFFF_FFFF, 32'h0, 16'h0, 20'h80000, F3_ADD,
			0, 0, 1, 0));
		issue_instr(make_instr(FMT_S, 32'h7FFF_FFFF, 32'h0, 16'h0, 20'h00001, F3_ADD,
			0, 0, 0, 0));
		// lui and auipc at the immediate extremes
		issue_instr(make_instr(FMT_U, 32'h0, 32'h0, 16'h0, 20'hFFFFF, F3_ADD, 0, 0, 0, 1));
		issue_instr(make_instr(FMT_U, 32'h0, 32'h0, 16'hFFFF, 20'h7FFFF, F3_ADD, 0, 0, 0, 0));
		// unused format codes, jalr flag outside its format
		issue_instr(make_instr(FMT_RSV6, 32'h0000_0FFF, 32'h0, 16'h0, 20'h00003, F3_SR,
			1, 1, 1, 1));
		issue_instr(make_instr(FMT_RSV7, 32'hFFFF_FFFF, 32'h0, 16'h8000, 20'hFFFFF, F3_SLTU,
			0, 0, 1, 1));
	endtask

	// random instructions with idle gaps, then a full drain
	task automatic test_random_gaps(input int unsigned n);
		gaps_on = 1'b1;
		repeat (n) issue_instr(random_instr(1'b0));
		drain_results();
	endtask

	// random instructions back to back, no idle cycles at all
	task automatic test_back_to_back(input int unsigned n);
		gaps_on = 1'b0;
		repeat (n) issue_instr(random_instr(1'b0));
		gaps_on = 1'b1;
	endtask

	// operands and immediates mostly at their edges
	task automatic test_edge_operands(input int unsigned n);
		gaps_on = 1'b1;
		repeat (n) issue_instr(random_instr(1'b1));
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cmd       <= '0;
		rs1_value <= '0;
		rs2_value <= '0;
		pc_value  <= '0;
		immediate <= '0;
		funct3    <= '0;
		alt_bit   <= 1'b0;
		jalr_flag <= 1'b0;
		load_flag <= 1'b0;
		lui_flag  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_gaps(1000);
		test_back_to_back(500);
		test_edge_operands(400);

		// let every outstanding result come back, then watch for strays
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
